/* sv/sha1_byte_stream_hasher_top_defines.svh */
// Assertion macros used by the checker file.
// Both expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef SHA1_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// same-cycle implication
`define SBH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SBH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/sbh_pkg.sv */
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types and constants of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sbh_pkg;

    // command queue between front and core
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int NUM_WORDS = 5;

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [5:0] FILL_LENPOS = 6'd56;
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [2:0] WORD_LAST   = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_cmd;

endpackage

/* sv/sbh_front.sv */
// ----------------------------------------------------------------------------
// sbh_front
// Input side: takes items, drops empty ones, queues the rest for the core.
// ----------------------------------------------------------------------------
module sbh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_data_byte,
    input  logic              i_byte_present,
    input  logic              i_message_end,
    output logic              o_cmd_valid,
    output sbh_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    sbh_pkg::t_cmd                 r_mem [sbh_pkg::QDEPTH];
    logic [sbh_pkg::QPTR_W-1:0]    r_wptr, n_wptr;
    logic [sbh_pkg::QPTR_W-1:0]    r_rptr, n_rptr;
    logic [sbh_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                          w_xfer;
    logic                          w_enq;
    logic                          w_deq;
    sbh_pkg::t_cmd                 w_cmd;

    assign full        = (r_count == sbh_pkg::QCNT_W'(sbh_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rptr];

    assign w_xfer = push && !full;
    // an item with neither byte nor end mark has no effect, so it is not queued
    assign w_enq  = w_xfer && (i_byte_present || i_message_end);
    assign w_deq  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        w_cmd.data_byte    = i_data_byte;
        w_cmd.byte_present = i_byte_present;
        w_cmd.message_end  = i_message_end;
        n_wptr  = w_enq ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = w_deq ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (w_enq && !w_deq) begin
            n_count = r_count + 1'b1;
        end else if (!w_enq && w_deq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

endmodule

/* sv/sbh_core.sv */
// ----------------------------------------------------------------------------
// sbh_core
// Back side: block gathering, padding, 80-round compression, digest output.
// ----------------------------------------------------------------------------
module sbh_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  sbh_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_ROUND,
        S_ADD,
        S_DIGEST
    } t_state;

    t_state         r_state, n_state;
    t_state         r_ret, n_ret;
    t_state         w_after;
    logic [5:0]     r_fill, n_fill;
    logic [63:0]    r_len, n_len;
    logic [6:0]     r_round, n_round;
    logic [2:0]     r_widx, n_widx;
    logic [511:0]   r_window, n_window;
    logic [31:0]    r_chain [sbh_pkg::NUM_WORDS];
    logic [31:0]    n_chain [sbh_pkg::NUM_WORDS];
    logic [31:0]    r_wk [sbh_pkg::NUM_WORDS];
    logic [31:0]    n_wk [sbh_pkg::NUM_WORDS];
    logic           r_ovld, n_ovld;
    logic [31:0]    r_oword, n_oword;
    logic [2:0]     r_oidx, n_oidx;
    logic           r_olast, n_olast;

    logic           w_push;
    logic [7:0]     w_pbyte;
    logic [31:0]    w_sched;
    logic [31:0]    w_f;
    logic [31:0]    w_k;
    logic [31:0]    w_t;

    assign empty         = !r_ovld;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;

    // round function; window word 0 is W[t], words 2, 8 and 13 feed W[t+16]
    always_comb begin
        w_sched = r_window[95:64] ^ r_window[255:224] ^ r_window[447:416]
                ^ r_window[511:480];
        if (r_round < 7'd20) begin
            w_f = (r_wk[1] & r_wk[2]) | (~r_wk[1] & r_wk[3]);
            w_k = sbh_pkg::K_0;
        end else if (r_round < 7'd40) begin
            w_f = r_wk[1] ^ r_wk[2] ^ r_wk[3];
            w_k = sbh_pkg::K_1;
        end else if (r_round < 7'd60) begin
            w_f = (r_wk[1] & r_wk[2]) | (r_wk[1] & r_wk[3]) | (r_wk[2] & r_wk[3]);
            w_k = sbh_pkg::K_2;
        end else begin
            w_f = r_wk[1] ^ r_wk[2] ^ r_wk[3];
            w_k = sbh_pkg::K_3;
        end
        w_t = {r_wk[0][26:0], r_wk[0][31:27]} + w_f + r_wk[4] + w_k
            + r_window[511:480];
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_fill   = r_fill;
        n_len    = r_len;
        n_round  = r_round;
        n_widx   = r_widx;
        n_window = r_window;
        n_chain  = r_chain;
        n_wk     = r_wk;
        n_oword  = r_oword;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        n_ovld   = (pop && r_ovld) ? 1'b0 : r_ovld;
        o_cmd_pop = 1'b0;
        w_push   = 1'b0;
        w_pbyte  = '0;
        w_after  = r_state;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.byte_present) begin
                        w_push  = 1'b1;
                        w_pbyte = i_cmd.data_byte;
                        n_len   = r_len + 64'd8;
                    end
                    w_after = i_cmd.message_end ? S_PAD80 : S_IDLE;
                    n_state = w_after;
                end
            end
            S_PAD80: begin
                w_push  = 1'b1;
                w_pbyte = sbh_pkg::PAD_BYTE;
                w_after = S_ZERO;
            end
            S_ZERO: begin
                if (r_fill == sbh_pkg::FILL_LENPOS) begin
                    n_state = S_LEN;
                end else begin
                    w_push  = 1'b1;
                    w_after = S_ZERO;
                end
            end
            S_LEN: begin
                // length goes out MSB first; shifting leaves it zero for the next message
                w_push  = 1'b1;
                w_pbyte = r_len[63:56];
                n_len   = {r_len[55:0], 8'h00};
                w_after = (r_fill == sbh_pkg::FILL_LAST) ? S_DIGEST : S_LEN;
            end
            S_ROUND: begin
                n_wk[0]  = w_t;
                n_wk[1]  = r_wk[0];
                n_wk[2]  = {r_wk[1][1:0], r_wk[1][31:2]};
                n_wk[3]  = r_wk[2];
                n_wk[4]  = r_wk[3];
                n_window = {r_window[479:0], w_sched[30:0], w_sched[31]};
                if (r_round == sbh_pkg::ROUND_LAST) begin
                    n_round = '0;
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            S_ADD: begin
                for (int i = 0; i < sbh_pkg::NUM_WORDS; i++) begin
                    n_chain[i] = r_chain[i] + r_wk[i];
                end
                n_state = r_ret;
            end
            S_DIGEST: begin
                if (!r_ovld || pop) begin
                    n_ovld  = 1'b1;
                    n_oword = r_chain[r_widx];
                    n_oidx  = r_widx;
                    n_olast = (r_widx == sbh_pkg::WORD_LAST);
                    if (r_widx == sbh_pkg::WORD_LAST) begin
                        n_widx  = '0;
                        n_chain = sbh_pkg::H_INIT;
                        n_state = S_IDLE;
                    end else begin
                        n_widx = r_widx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push) begin
            n_window = {r_window[503:0], w_pbyte};
            n_fill   = r_fill + 1'b1;
            if (r_fill == sbh_pkg::FILL_LAST) begin
                // block complete: compress, then continue where the byte flow left off
                n_state = S_ROUND;
                n_ret   = w_after;
                n_wk    = r_chain;
            end else begin
                n_state = w_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_round <= '0;
            r_widx  <= '0;
            r_chain <= sbh_pkg::H_INIT;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_round <= n_round;
            r_widx  <= n_widx;
            r_chain <= n_chain;
            r_ovld  <= n_ovld;
        end
        r_window <= n_window;
        r_wk     <= n_wk;
        r_oword  <= n_oword;
        r_oidx   <= n_oidx;
        r_olast  <= n_olast;
    end

endmodule

/* sv/sha1_byte_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_top
// SHA-1 hasher over a stream of byte items, digest out as five words.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each transfer carries at most one message byte
// (i_byte_present) and an optional end mark (i_message_end); an item with
// neither is a no-op. Items go into a 4-entry command queue, so the source
// keeps pushing while the core pads, compresses or waits on the output.
// Output channel: empty/pop. After an end mark, five words leave in order,
// h0 first, o_word_index 0..4, o_last_word on word 4; the hasher then starts
// over from the initial chaining values.
// In the core, message bytes go in one per cycle while items wait in the
// queue; each full 64-byte block is compressed in 80 rounds through one round
// unit, then the chaining add. At the end mark, the padding and length
// bytes go in (9 to 72 bytes) with one or two block compressions, then one
// digest word leaves per cycle while the receiver pops.
// Throughput is set by the byte-wide block fill and the single round unit;
// the core takes no new byte while it compresses a block.
// Reset (synchronous, active low) empties the queue and output register and
// loads the initial chaining values. A stalled receiver holds the current
// word; the core stops on digest output and the queue fills until full rises.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic           w_cmd_valid;
    logic           w_cmd_pop;
    sbh_pkg::t_cmd  w_cmd;

    sbh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_message_end  (i_message_end),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    sbh_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .empty          (empty),
        .pop            (pop),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

endmodule

/* sv/sbh_checker.sv */
// ----------------------------------------------------------------------------
// sbh_checker
// Port-level checks of the hasher's digest output sequence.
// ----------------------------------------------------------------------------
`include "sha1_byte_stream_hasher_top_defines.svh"

module sbh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] o_digest_word,
    input  logic [2:0]  o_word_index,
    input  logic        o_last_word
);

    `SBH_ASSERT_NOW(a_last_on_word4, !empty, o_last_word == (o_word_index == 3'd4))

    `SBH_ASSERT_NOW(a_index_range, !empty, o_word_index <= 3'd4)

    // words of one digest come out in index order
    `SBH_ASSERT_NEXT(a_index_step, !empty && pop && !o_last_word,
        empty || (o_word_index == $past(o_word_index) + 3'd1))

    // the next digest needs at least one compression, so nothing follows word 4 at once
    `SBH_ASSERT_NEXT(a_gap_after_last, !empty && pop && o_last_word, empty)

    `SBH_ASSERT_NEXT(a_hold_on_stall, !empty && !pop,
        !empty && $stable(o_digest_word) && $stable(o_word_index))

endmodule

bind sha1_byte_stream_hasher_top sbh_checker u_sbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
